>>> hdl/wlss_pkg.sv
// ----------------------------------------------------------------------------
// wlss_pkg
// Shared types, constants and lookup functions for the wavetable lane
// sample source.
// ----------------------------------------------------------------------------
package wlss_pkg;

    localparam int LANE_COUNT  = 8;
    localparam int WAVE_STEPS  = 32;
    localparam int STORE_DEPTH = LANE_COUNT * WAVE_STEPS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int LANE_W   = 3;
    localparam int IDX_W    = 5;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Opcodes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Chip modes.
    localparam logic [1:0] MODE_5BIT = 2'd0;
    localparam logic [1:0] MODE_4BIT = 2'd1;
    localparam logic [1:0] MODE_8BIT = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_CHOICES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_FLAGS  = 2'd3;

    // Shape choices.
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_SAW      = 3'd1;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
    localparam logic [2:0] SHAPE_PULSE    = 3'd3;
    localparam logic [2:0] SHAPE_PATTERN  = 3'd4;

    typedef struct packed {
        logic [1:0]  chip_mode;
        logic [23:0] shape_choices;
        logic [4:0]  pulse_threshold;
        logic [7:0]  custom_lane_flags;
    } cfg_t;

    // Choices above the pattern code act as the pattern.
    function automatic logic [2:0] clamp_choice(input logic [2:0] c);
        clamp_choice = (c > SHAPE_PATTERN) ? SHAPE_PATTERN : c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] mode_max(input logic [1:0] mode);
        unique case (mode)
            MODE_5BIT: mode_max = 8'd31;
            MODE_4BIT: mode_max = 8'd15;
            default:   mode_max = 8'd255;
        endcase
    endfunction

    function automatic logic [3:0] mode_lanes(input logic [1:0] mode);
        unique case (mode)
            MODE_5BIT: mode_lanes = 4'd6;
            MODE_4BIT: mode_lanes = 4'd8;
            MODE_8BIT: mode_lanes = 4'd5;
            default:   mode_lanes = 4'd0;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sine5(input logic [IDX_W-1:0] i);
        case (i)
            5'd0:  sine5 = 8'd16;  5'd1:  sine5 = 8'd19;  5'd2:  sine5 = 8'd21;
            5'd3:  sine5 = 8'd24;  5'd4:  sine5 = 8'd26;  5'd5:  sine5 = 8'd28;
            5'd6:  sine5 = 8'd30;  5'd7:  sine5 = 8'd31;  5'd8:  sine5 = 8'd31;
            5'd9:  sine5 = 8'd31;  5'd10: sine5 = 8'd30;  5'd11: sine5 = 8'd28;
            5'd12: sine5 = 8'd26;  5'd13: sine5 = 8'd24;  5'd14: sine5 = 8'd21;
            5'd15: sine5 = 8'd19;  5'd16: sine5 = 8'd16;  5'd17: sine5 = 8'd12;
            5'd18: sine5 = 8'd10;  5'd19: sine5 = 8'd7;   5'd20: sine5 = 8'd5;
            5'd21: sine5 = 8'd3;   5'd22: sine5 = 8'd1;   5'd23: sine5 = 8'd0;
            5'd24: sine5 = 8'd0;   5'd25: sine5 = 8'd0;   5'd26: sine5 = 8'd1;
            5'd27: sine5 = 8'd3;   5'd28: sine5 = 8'd5;   5'd29: sine5 = 8'd7;
            5'd30: sine5 = 8'd10;  default: sine5 = 8'd12;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sine4(input logic [IDX_W-1:0] i);
        case (i)
            5'd0:  sine4 = 8'd8;   5'd1:  sine4 = 8'd9;   5'd2:  sine4 = 8'd10;
            5'd3:  sine4 = 8'd12;  5'd4:  sine4 = 8'd13;  5'd5:  sine4 = 8'd14;
            5'd6:  sine4 = 8'd14;  5'd7:  sine4 = 8'd15;  5'd8:  sine4 = 8'd15;
            5'd9:  sine4 = 8'd15;  5'd10: sine4 = 8'd14;  5'd11: sine4 = 8'd14;
            5'd12: sine4 = 8'd13;  5'd13: sine4 = 8'd12;  5'd14: sine4 = 8'd10;
            5'd15: sine4 = 8'd9;   5'd16: sine4 = 8'd8;   5'd17: sine4 = 8'd6;
            5'd18: sine4 = 8'd5;   5'd19: sine4 = 8'd3;   5'd20: sine4 = 8'd2;
            5'd21: sine4 = 8'd1;   5'd22: sine4 = 8'd1;   5'd23: sine4 = 8'd0;
            5'd24: sine4 = 8'd0;   5'd25: sine4 = 8'd0;   5'd26: sine4 = 8'd1;
            5'd27: sine4 = 8'd1;   5'd28: sine4 = 8'd2;   5'd29: sine4 = 8'd3;
            5'd30: sine4 = 8'd5;   default: sine4 = 8'd6;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sine8(input logic [IDX_W-1:0] i);
        case (i)
            5'd0:  sine8 = 8'd128; 5'd1:  sine8 = 8'd153; 5'd2:  sine8 = 8'd177;
            5'd3:  sine8 = 8'd199; 5'd4:  sine8 = 8'd218; 5'd5:  sine8 = 8'd234;
            5'd6:  sine8 = 8'd245; 5'd7:  sine8 = 8'd253; 5'd8:  sine8 = 8'd255;
            5'd9:  sine8 = 8'd253; 5'd10: sine8 = 8'd245; 5'd11: sine8 = 8'd234;
            5'd12: sine8 = 8'd218; 5'd13: sine8 = 8'd199; 5'd14: sine8 = 8'd177;
            5'd15: sine8 = 8'd153; 5'd16: sine8 = 8'd128; 5'd17: sine8 = 8'd103;
            5'd18: sine8 = 8'd79;  5'd19: sine8 = 8'd57;  5'd20: sine8 = 8'd38;
            5'd21: sine8 = 8'd22;  5'd22: sine8 = 8'd11;  5'd23: sine8 = 8'd3;
            5'd24: sine8 = 8'd1;   5'd25: sine8 = 8'd3;   5'd26: sine8 = 8'd11;
            5'd27: sine8 = 8'd22;  5'd28: sine8 = 8'd38;  5'd29: sine8 = 8'd57;
            5'd30: sine8 = 8'd79;  default: sine8 = 8'd103;
        endcase
    endfunction

endpackage

>>> hdl/wlss_store.sv
// ----------------------------------------------------------------------------
// wlss_store
// Custom sample store: one synchronous memory with a registered read port
// and one valid bit per entry, so that entries never written read as zero.
// ----------------------------------------------------------------------------
module wlss_store
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [wlss_pkg::ADDR_W-1:0]           wr_addr,
    input  logic [wlss_pkg::SAMPLE_W-1:0]         wr_data,
    input  logic                                  rd_en,
    input  logic [wlss_pkg::ADDR_W-1:0]           rd_addr,
    output logic [wlss_pkg::SAMPLE_W-1:0]         rd_data
);

    logic [wlss_pkg::SAMPLE_W-1:0]    mem [wlss_pkg::STORE_DEPTH];
    logic [wlss_pkg::STORE_DEPTH-1:0] valid_reg;
    logic [wlss_pkg::SAMPLE_W-1:0]    rd_word_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry that was never written since reset reads as zero.
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

>>> hdl/wlss_shape.sv
// ----------------------------------------------------------------------------
// wlss_shape
// Generated wave shapes: sine, saw, triangle, pulse and the index and lane
// pattern, for the lane's effective shape choice in the current mode.
// ----------------------------------------------------------------------------
module wlss_shape
(
    input  wlss_pkg::cfg_t                   cfg,
    input  logic [wlss_pkg::LANE_W-1:0]      lane,
    input  logic [wlss_pkg::IDX_W-1:0]       idx,
    output logic [wlss_pkg::SAMPLE_W-1:0]    shape_value
);

    logic [2:0]  own_choice;
    logic [2:0]  choice;
    logic [7:0]  maxv;
    logic [12:0] saw_prod;
    logic [12:0] saw_sum;
    logic [3:0]  tri_t;
    logic [7:0]  tri_value;
    logic [7:0]  sine_value;
    logic        pulse_high;
    logic [7:0]  pat5;
    logic [7:0]  pat4;
    logic [7:0]  pat8;
    logic [7:0]  pat_value;

    always_comb
    begin
        own_choice = wlss_pkg::clamp_choice(cfg.shape_choices[3*lane +: 3]);
        // A zero choice defers to lane 0's choice.
        choice = (own_choice == wlss_pkg::SHAPE_SINE)
               ? wlss_pkg::clamp_choice(cfg.shape_choices[2:0]) : own_choice;
        maxv = wlss_pkg::mode_max(cfg.chip_mode);

        saw_prod = 13'(maxv) * 13'(idx);
        saw_sum  = saw_prod + 13'd16;

        // Folded index for the triangle; the second half counts down.
        tri_t = idx[4] ? ~idx[3:0] : idx[3:0];
        unique case (cfg.chip_mode)
            wlss_pkg::MODE_5BIT: tri_value = 8'({tri_t, 1'b0}) + 8'(tri_t[3]);
            wlss_pkg::MODE_4BIT: tri_value = 8'(tri_t);
            default:             tri_value = {tri_t, tri_t};
        endcase

        unique case (cfg.chip_mode)
            wlss_pkg::MODE_5BIT: sine_value = wlss_pkg::sine5(idx);
            wlss_pkg::MODE_4BIT: sine_value = wlss_pkg::sine4(idx);
            default:             sine_value = wlss_pkg::sine8(idx);
        endcase

        if (cfg.chip_mode == wlss_pkg::MODE_5BIT)
        begin
            pulse_high = ~idx[4];
        end
        else
        begin
            pulse_high = idx < cfg.pulse_threshold;
        end

        pat5 = 8'(idx) * 8'd13 + 8'(lane) * 8'd7;
        pat4 = 8'(idx) * 8'd5 + 8'(lane) * 8'd3;
        pat8 = 8'(idx) * 8'd17 + 8'(lane) * 8'd29;
        unique case (cfg.chip_mode)
            wlss_pkg::MODE_5BIT: pat_value = {3'd0, pat5[4:0]};
            wlss_pkg::MODE_4BIT: pat_value = {4'd0, pat4[3:0]};
            default:             pat_value = pat8;
        endcase

        case (choice)
            wlss_pkg::SHAPE_SAW:      shape_value = saw_sum[12:5];
            wlss_pkg::SHAPE_TRIANGLE: shape_value = tri_value;
            wlss_pkg::SHAPE_PULSE:    shape_value = pulse_high ? maxv : 8'd0;
            wlss_pkg::SHAPE_PATTERN:  shape_value = pat_value;
            default:                  shape_value = sine_value;
        endcase
    end

endmodule

>>> hdl/wavetable_lane_sample_source_unit.sv
// Path: a read word's store read and its stage 1 registers are loaded when the word
// is accepted; its result then enters the output register, which a stalled output holds back.
// Throughput: one word per cycle, read or write, with no bubbles between words, while
// the output is not stalled. Each word makes one custom store access on a shared address.
// Reset: asynchronous, active low; registers return to their reset values and
// all custom store valid bits clear at once, so the store reads as zero.
// ----------------------------------------------------------------------------
// wavetable_lane_sample_source_unit
// Answers one wavetable sample per read word for a lane and a 32-step index,
// and fills the custom sample store on write words.
// ----------------------------------------------------------------------------
module wavetable_lane_sample_source_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wlss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wlss_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Input word channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [wlss_pkg::LANE_W-1:0]         lane,
    input  logic [wlss_pkg::IDX_W-1:0]          sample_index,
    input  logic [wlss_pkg::SAMPLE_W-1:0]       write_value,

    // Result word channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wlss_pkg::SAMPLE_W-1:0]       sample_value
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; software must only
    // change them while no word is in flight, which the block does not enforce.
    // ------------------------------------------------------------------
    logic [1:0]  chip_mode_reg;
    logic [23:0] shape_choices_reg;
    logic [4:0]  pulse_threshold_reg;
    logic [7:0]  custom_flags_reg;
    wlss_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_mode_reg       <= wlss_pkg::MODE_NONE;
            shape_choices_reg   <= '0;
            pulse_threshold_reg <= 5'd16;
            custom_flags_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wlss_pkg::CFG_CHIP_MODE:     chip_mode_reg       <= cfg_data[1:0];
                wlss_pkg::CFG_SHAPE_CHOICES: shape_choices_reg   <= cfg_data[23:0];
                wlss_pkg::CFG_PULSE_THRESH:  pulse_threshold_reg <= cfg_data[4:0];
                default:                     custom_flags_reg    <= cfg_data[7:0];
            endcase
        end
    end

    assign cfg.chip_mode         = chip_mode_reg;
    assign cfg.shape_choices     = shape_choices_reg;
    assign cfg.pulse_threshold   = pulse_threshold_reg;
    assign cfg.custom_lane_flags = custom_flags_reg;

    // ------------------------------------------------------------------
    // Pipeline control. Stage 1 holds the word whose store read is in
    // flight; the output register holds the finished result. A write word
    // updates the store at the edge it is accepted, so a read of the same
    // entry on the next word already sees the new data and no forwarding
    // path is needed. A write word leaves stage 1 without a result.
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic                             s1_op_reg;
    logic [wlss_pkg::LANE_W-1:0]      s1_lane_reg;
    logic [wlss_pkg::IDX_W-1:0]       s1_idx_reg;
    logic                             out_valid_reg;
    logic [wlss_pkg::SAMPLE_W-1:0]    out_sample_reg;
    logic [wlss_pkg::SAMPLE_W-1:0]    out_limit_reg;

    logic                             in_accept;
    logic                             out_en;
    logic                             s1_free;
    logic                             s1_is_read;
    logic                             wr_en;
    logic                             rd_en;
    logic [wlss_pkg::ADDR_W-1:0]      store_addr;
    logic [wlss_pkg::SAMPLE_W-1:0]    store_data;

    assign out_en     = !out_valid_reg || out_ready;
    assign s1_is_read = s1_valid_reg && (s1_op_reg == wlss_pkg::OP_READ);
    assign s1_free    = !s1_is_read || out_en;
    assign in_ready   = s1_free;
    assign in_accept  = in_valid && in_ready;

    // Entry address is lane * WAVE_STEPS + index; lanes beyond the store are
    // never written and their reads are forced to zero below.
    assign store_addr = wlss_pkg::ADDR_W'({lane, sample_index});
    assign wr_en = in_accept && (opcode == wlss_pkg::OP_WRITE)
                && ({1'b0, lane} < 4'(wlss_pkg::LANE_COUNT));
    assign rd_en = in_accept && (opcode == wlss_pkg::OP_READ);

    wlss_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (store_addr),
        .wr_data (write_value),
        .rd_en   (rd_en),
        .rd_addr (store_addr),
        .rd_data (store_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_op_reg   <= opcode;
            s1_lane_reg <= lane;
            s1_idx_reg  <= sample_index;
        end
    end

    // ------------------------------------------------------------------
    // Result selection for the word in stage 1.
    // ------------------------------------------------------------------
    logic [wlss_pkg::SAMPLE_W-1:0] shape_value;
    logic [wlss_pkg::SAMPLE_W-1:0] maxv;
    logic [wlss_pkg::SAMPLE_W-1:0] custom_value;
    logic                          lane_live;
    logic [wlss_pkg::SAMPLE_W-1:0] result_next;
    logic [wlss_pkg::SAMPLE_W-1:0] limit_next;

    wlss_shape u_shape
    (
        .cfg         (cfg),
        .lane        (s1_lane_reg),
        .idx         (s1_idx_reg),
        .shape_value (shape_value)
    );

    always_comb
    begin
        maxv = wlss_pkg::mode_max(cfg.chip_mode);
        // Lanes past the mode's count, or past the store, read as silence;
        // the none mode has a count of zero.
        lane_live = ({1'b0, s1_lane_reg} < wlss_pkg::mode_lanes(cfg.chip_mode))
                 && ({1'b0, s1_lane_reg} < 4'(wlss_pkg::LANE_COUNT));
        custom_value = (store_data > maxv) ? maxv : store_data;
        if (!lane_live)
        begin
            result_next = '0;
        end
        else if (cfg.custom_lane_flags[s1_lane_reg])
        begin
            result_next = custom_value;
        end
        else
        begin
            result_next = shape_value;
        end
        limit_next = (cfg.chip_mode == wlss_pkg::MODE_NONE) ? '0 : maxv;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s1_is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_sample_reg <= result_next;
            out_limit_reg  <= limit_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_sample_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A result never exceeds the maximum of the mode it was produced in.
    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_sample_reg <= out_limit_reg))
        else $error("sample above mode maximum");

    // With the output register empty the block must take a new word.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    // A read word blocked in stage 1 keeps its place and its store data.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_is_read && !out_en) |=>
            (s1_is_read && $stable(s1_lane_reg) && $stable(s1_idx_reg)
             && $stable(store_data)))
        else $error("stage 1 word lost while stalled");

endmodule
